// ===== rtl/perifocal_to_inertial_rotation_top_assert.svh =====
// Assertion macros used by the checker file p2i_check.sv.
`ifndef PERIFOCAL_TO_INERTIAL_ROTATION_TOP_ASSERT_SVH
`define PERIFOCAL_TO_INERTIAL_ROTATION_TOP_ASSERT_SVH

// same-cycle implication, masked while in reset
`define P2I_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while in reset
`define P2I_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, checked through reset
`define P2I_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/p2i_pkg.sv =====
`default_nettype none
package p2i_pkg;

    localparam int ANGLE_BITS  = 16;
    localparam int VECTOR_BITS = 32;
    localparam int LOW_BITS    = 24;
    localparam int HI_BITS     = VECTOR_BITS - LOW_BITS;

    localparam int TRIG_BITS   = 16;
    localparam int E_BITS      = 34;

    // pipeline depths
    localparam int SIN_LAT  = 8;
    localparam int MAT_LAT  = 2;
    localparam int LANE_LAT = 2;
    localparam int VEC_DLY  = SIN_LAT + MAT_LAT;
    localparam int PIPE_LAT = VEC_DLY + LANE_LAT + 1;

    // sin(pi/2*x) Taylor coefficients, Q30
    localparam logic [30:0] K1 = 31'd1686629713;
    localparam logic [30:0] K3 = 31'd693598668;
    localparam logic [30:0] K5 = 31'd85569306;
    localparam logic [30:0] K7 = 31'd5026994;
    localparam logic [30:0] K9 = 31'd172271;
    localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
    localparam logic [61:0] HALF_Q30 = 62'h2000_0000;

    typedef logic signed [TRIG_BITS-1:0]   t_trig;
    typedef logic signed [E_BITS-1:0]      t_entry;
    typedef logic signed [VECTOR_BITS-1:0] t_vec;
    typedef logic [ANGLE_BITS-1:0]         t_angle;

    function automatic logic [30:0] mul_q30(input logic [30:0] a, input logic [30:0] b);
        logic [61:0] pr;
        pr = 62'(a) * 62'(b) + HALF_Q30;
        return pr[60:30];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/p2i_if.sv =====
`default_nettype none
interface p2i_in_if;
    import p2i_pkg::*;

    logic   valid;
    logic   ready;
    t_angle inclination_angle;
    t_angle node_angle;
    t_angle perigee_angle;
    t_vec   p_component;
    t_vec   q_component;
    t_vec   w_component;

    modport source (output valid, output inclination_angle, output node_angle,
                    output perigee_angle, output p_component, output q_component,
                    output w_component, input ready);
    modport sink   (input valid, input inclination_angle, input node_angle,
                    input perigee_angle, input p_component, input q_component,
                    input w_component, output ready);
endinterface

interface p2i_out_if;
    import p2i_pkg::*;

    logic valid;
    logic ready;
    t_vec x_inertial;
    t_vec y_inertial;
    t_vec z_inertial;

    modport source (output valid, output x_inertial, output y_inertial,
                    output z_inertial, input ready);
    modport sink   (input valid, input x_inertial, input y_inertial,
                    input z_inertial, output ready);
endinterface
`default_nettype wire

// ===== rtl/perifocal_to_inertial_rotation_top.sv =====
`default_nettype none
// Channel  Dir  Beat contents
// i_in     in   three angles (turn fractions) + P/Q/W components
// o_out    out  inertial X/Y/Z, rounded and saturated
//
// One beat per cycle while o_out is not stalled; stages: 8 sine,
// 2 matrix, 2 row-lane multiply/sum, 1 output register.
// All stages advance together; a stalled output beat freezes the whole
// pipeline and deasserts i_in.ready.
// i_rst_n is synchronous; it clears only the stage valid bits.
module perifocal_to_inertial_rotation_top (
    input  logic  i_clk,
    input  logic  i_rst_n,
    p2i_in_if.sink    i_in,
    p2i_out_if.source o_out
);
    import p2i_pkg::*;

    localparam t_angle QUARTER = t_angle'(1) << (ANGLE_BITS - 2);

    logic   en;
    logic   r_vld [0:PIPE_LAT-1];
    t_vec   r_vec [0:VEC_DLY-1][0:2];
    t_trig  si, ci, so, co, sw, cw;
    t_entry ent [0:2][0:2];
    t_vec   res [0:2];
    t_vec   r_x, r_y, r_z;

    assign en         = !r_vld[PIPE_LAT-1] || o_out.ready;
    assign i_in.ready = en;

    p2i_sine u_sin_i (.i_clk, .i_en(en), .i_angle(i_in.inclination_angle), .o_sin(si));
    p2i_sine u_cos_i (.i_clk, .i_en(en),
                      .i_angle(t_angle'(i_in.inclination_angle + QUARTER)), .o_sin(ci));
    p2i_sine u_sin_o (.i_clk, .i_en(en), .i_angle(i_in.node_angle), .o_sin(so));
    p2i_sine u_cos_o (.i_clk, .i_en(en),
                      .i_angle(t_angle'(i_in.node_angle + QUARTER)), .o_sin(co));
    p2i_sine u_sin_w (.i_clk, .i_en(en), .i_angle(i_in.perigee_angle), .o_sin(sw));
    p2i_sine u_cos_w (.i_clk, .i_en(en),
                      .i_angle(t_angle'(i_in.perigee_angle + QUARTER)), .o_sin(cw));

    p2i_matrix u_mat (
        .i_clk, .i_en(en),
        .i_si(si), .i_ci(ci), .i_so(so), .i_co(co), .i_sw(sw), .i_cw(cw),
        .o_ent(ent)
    );

    // components wait for the rotation matrix
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vec[0][0] <= i_in.p_component;
            r_vec[0][1] <= i_in.q_component;
            r_vec[0][2] <= i_in.w_component;
            for (int k = 1; k < VEC_DLY; k++) r_vec[k] <= r_vec[k-1];
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        p2i_lane u_lane (
            .i_clk, .i_en(en),
            .i_ent(ent[g]), .i_vec(r_vec[VEC_DLY-1]),
            .o_res(res[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PIPE_LAT; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_in.valid;
            for (int k = 1; k < PIPE_LAT; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // merge: lanes land in one output beat
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x <= res[0];
            r_y <= res[1];
            r_z <= res[2];
        end
    end

    assign o_out.valid      = r_vld[PIPE_LAT-1];
    assign o_out.x_inertial = r_x;
    assign o_out.y_inertial = r_y;
    assign o_out.z_inertial = r_z;

endmodule
`default_nettype wire

// ===== rtl/p2i_sine.sv =====
`default_nettype none
module p2i_sine (
    input  logic            i_clk,
    input  logic            i_en,
    input  p2i_pkg::t_angle i_angle,
    output p2i_pkg::t_trig  o_sin
);
    import p2i_pkg::*;

    logic [1:0]  quad;
    logic [29:0] x_raw;
    logic [30:0] x_fold;

    logic [30:0] r_x    [0:5];
    logic [1:0]  r_quad [0:6];
    logic [30:0] r_x2   [0:3];
    logic [30:0] r_p    [0:3];
    logic [30:0] r_s;
    t_trig       r_sin;

    logic [31:0] s_rnd;
    logic [16:0] mag;
    logic [15:0] mag_cap;

    assign quad   = i_angle[ANGLE_BITS-1:ANGLE_BITS-2];
    assign x_raw  = {i_angle[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}};
    // odd quadrants run the quarter wave backwards
    assign x_fold = quad[0] ? (ONE_Q30 - {1'b0, x_raw}) : {1'b0, x_raw};

    assign s_rnd   = {1'b0, r_s} + 32'd16384;
    assign mag     = s_rnd[31:15];
    assign mag_cap = (mag > 17'd32767) ? 16'd32767 : mag[15:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= x_fold;
            r_quad[0] <= quad;
            for (int k = 1; k < 6; k++) r_x[k] <= r_x[k-1];
            for (int k = 1; k < 7; k++) r_quad[k] <= r_quad[k-1];

            r_x2[0] <= mul_q30(r_x[0], r_x[0]);
            for (int k = 1; k < 4; k++) r_x2[k] <= r_x2[k-1];

            // Horner, one coefficient per stage
            r_p[0] <= K7 - mul_q30(K9, r_x2[0]);
            r_p[1] <= K5 - mul_q30(r_p[0], r_x2[1]);
            r_p[2] <= K3 - mul_q30(r_p[1], r_x2[2]);
            r_p[3] <= K1 - mul_q30(r_p[2], r_x2[3]);

            r_s   <= mul_q30(r_p[3], r_x[5]);
            r_sin <= r_quad[6][1] ? -$signed(mag_cap) : $signed(mag_cap);
        end
    end

    assign o_sin = r_sin;

endmodule
`default_nettype wire

// ===== rtl/p2i_matrix.sv =====
`default_nettype none
module p2i_matrix (
    input  logic            i_clk,
    input  logic            i_en,
    input  p2i_pkg::t_trig  i_si,
    input  p2i_pkg::t_trig  i_ci,
    input  p2i_pkg::t_trig  i_so,
    input  p2i_pkg::t_trig  i_co,
    input  p2i_pkg::t_trig  i_sw,
    input  p2i_pkg::t_trig  i_cw,
    output p2i_pkg::t_entry o_ent [0:2][0:2]
);
    import p2i_pkg::*;

    typedef logic signed [31:0] t_pair;
    typedef logic signed [48:0] t_wide;

    t_pair  r_cocw, r_sosw, r_cosw, r_socw, r_sosi, r_cosi, r_swsi, r_cwsi;
    t_trig  r_ci;
    t_entry r_ent [0:2][0:2];

    function automatic t_entry q45(input t_wide v);
        t_wide t;
        t = v + 49'sd16384;
        return t_entry'(t >>> 15);
    endfunction

    function automatic t_wide sh15(input t_pair a);
        return t_wide'(a) <<< 15;
    endfunction

    function automatic t_wide by_ci(input t_pair a, input t_trig c);
        return t_wide'(a) * t_wide'(c);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cocw <= i_co * i_cw;
            r_sosw <= i_so * i_sw;
            r_cosw <= i_co * i_sw;
            r_socw <= i_so * i_cw;
            r_sosi <= i_so * i_si;
            r_cosi <= i_co * i_si;
            r_swsi <= i_sw * i_si;
            r_cwsi <= i_cw * i_si;
            r_ci   <= i_ci;

            r_ent[0][0] <= q45(sh15(r_cocw) - by_ci(r_sosw, r_ci));
            r_ent[0][1] <= q45(-sh15(r_cosw) - by_ci(r_socw, r_ci));
            r_ent[0][2] <= q45(sh15(r_sosi));
            r_ent[1][0] <= q45(sh15(r_socw) + by_ci(r_cosw, r_ci));
            r_ent[1][1] <= q45(-sh15(r_sosw) + by_ci(r_cocw, r_ci));
            r_ent[1][2] <= q45(-sh15(r_cosi));
            r_ent[2][0] <= q45(sh15(r_swsi));
            r_ent[2][1] <= q45(sh15(r_cwsi));
            r_ent[2][2] <= q45(t_wide'(r_ci) <<< 30);
        end
    end

    assign o_ent = r_ent;

endmodule
`default_nettype wire

// ===== rtl/p2i_lane.sv =====
`default_nettype none
module p2i_lane (
    input  logic            i_clk,
    input  logic            i_en,
    input  p2i_pkg::t_entry i_ent [0:2],
    input  p2i_pkg::t_vec   i_vec [0:2],
    output p2i_pkg::t_vec   o_res
);
    import p2i_pkg::*;

    localparam int EH_BITS = E_BITS + HI_BITS;
    localparam int EL_BITS = E_BITS + LOW_BITS + 1;
    localparam int HS_BITS = EH_BITS + 2;
    localparam int LS_BITS = EL_BITS + 2;
    localparam int HP_BITS = HS_BITS + 1;

    logic signed [EH_BITS-1:0] r_eh [0:2];
    logic signed [EL_BITS-1:0] r_el [0:2];
    logic signed [HS_BITS-1:0] r_h;
    logic signed [LS_BITS-1:0] r_l;

    logic signed [HP_BITS-1:0] hp;
    logic signed [HP_BITS-1:0] rr;
    logic [HP_BITS-VECTOR_BITS:0] top_bits;
    logic ovf;

    // each component split as hi*2^LOW_BITS + lo, lo unsigned
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_eh[k] <= EH_BITS'(i_ent[k]) *
                           EH_BITS'($signed(i_vec[k][VECTOR_BITS-1:LOW_BITS]));
                r_el[k] <= EL_BITS'(i_ent[k]) *
                           EL_BITS'($signed({1'b0, i_vec[k][LOW_BITS-1:0]}));
            end
            r_h <= HS_BITS'(r_eh[0]) + HS_BITS'(r_eh[1]) + HS_BITS'(r_eh[2]);
            r_l <= LS_BITS'(r_el[0]) + LS_BITS'(r_el[1]) + LS_BITS'(r_el[2]);
        end
    end

    assign hp       = HP_BITS'(r_h) + HP_BITS'(r_l >>> LOW_BITS);
    assign rr       = (hp + HP_BITS'(32)) >>> 6;
    assign top_bits = rr[HP_BITS-1:VECTOR_BITS-1];
    assign ovf      = !((&top_bits) || !(|top_bits));

    always_comb begin
        if (ovf) begin
            o_res = rr[HP_BITS-1] ? {1'b1, {(VECTOR_BITS-1){1'b0}}}
                                  : {1'b0, {(VECTOR_BITS-1){1'b1}}};
        end else begin
            o_res = rr[VECTOR_BITS-1:0];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/p2i_check.sv =====
`default_nettype none
`include "perifocal_to_inertial_rotation_top_assert.svh"
module p2i_check (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_ready,
    input wire logic          i_out_valid,
    input wire logic          i_out_ready,
    input wire p2i_pkg::t_vec i_x,
    input wire p2i_pkg::t_vec i_y,
    input wire p2i_pkg::t_vec i_z
);
    `P2I_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "output beat dropped while stalled")
    `P2I_ASSERT_NXT(a_out_stable, i_out_valid && !i_out_ready, $stable(i_x) && $stable(i_y) && $stable(i_z), "output beat changed while stalled")
    `P2I_ASSERT_IMP(a_in_ready, !i_out_valid || i_out_ready, i_in_ready, "input stalled with free pipeline")
    `P2I_ASSERT_RST(a_rst_clear, !i_rst_n, !i_out_valid, "output valid after reset")
endmodule

bind perifocal_to_inertial_rotation_top p2i_check u_p2i_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_x         (o_out.x_inertial),
    .i_y         (o_out.y_inertial),
    .i_z         (o_out.z_inertial)
);
`default_nettype wire

// ===== tb/sv/p2i_tb_pkg.sv =====
package p2i_tb_pkg;
    import p2i_pkg::*;

    typedef struct packed {
        t_angle incl;
        t_angle node;
        t_angle peri;
        t_vec   p;
        t_vec   q;
        t_vec   w;
    } t_orbit_beat;

    typedef struct packed {
        t_vec x;
        t_vec y;
        t_vec z;
    } t_eci_beat;

    localparam logic [31:0] TRIG_K1 = 32'd1686629713;
    localparam logic [31:0] TRIG_K3 = 32'd693598668;
    localparam logic [31:0] TRIG_K5 = 32'd85569306;
    localparam logic [31:0] TRIG_K7 = 32'd5026994;
    localparam logic [31:0] TRIG_K9 = 32'd172271;
    localparam longint QUARTER_TURN = longint'(1) << (ANGLE_BITS - 2);

    function automatic longint q30_mult(longint a, longint b);
        return (a * b + (longint'(1) << 29)) >>> 30;
    endfunction

    // Q1.15 sine of a turn fraction, polynomial on a folded quarter turn
    function automatic longint turn_sine(longint ang);
        longint a, x, x2, poly, s, r;
        int quad;
        a = ang & ((longint'(1) << ANGLE_BITS) - 1);
        quad = int'((a >> (ANGLE_BITS - 2)) & 3);
        x = (a & (QUARTER_TURN - 1)) << (32 - ANGLE_BITS);
        if (quad[0]) x = (longint'(1) << 30) - x;
        x2 = q30_mult(x, x);
        poly = TRIG_K7 - q30_mult(TRIG_K9, x2);
        poly = TRIG_K5 - q30_mult(poly, x2);
        poly = TRIG_K3 - q30_mult(poly, x2);
        poly = TRIG_K1 - q30_mult(poly, x2);
        s = q30_mult(poly, x);
        r = (s + 16384) >> 15;
        if (r > 32767) r = 32767;
        return quad[1] ? -r : r;
    endfunction

    function automatic longint turn_cosine(longint ang);
        return turn_sine(ang + QUARTER_TURN);
    endfunction

    function automatic longint q45_round(longint v);
        return (v + 16384) >>> 15;
    endfunction

    // 128-bit accumulate avoids the split that the hardware needs
    function automatic t_vec row_dot(longint e0, longint e1, longint e2, t_vec p, t_vec q,
                                     t_vec w);
        logic signed [127:0] acc;
        logic signed [127:0] r;
        acc = 128'(e0) * 128'(longint'(p)) + 128'(e1) * 128'(longint'(q))
            + 128'(e2) * 128'(longint'(w));
        r = (acc + (128'sd1 <<< 29)) >>> 30;
        if (r > 128'sd2147483647) r = 128'sd2147483647;
        if (r < -128'sd2147483648) r = -128'sd2147483648;
        return t_vec'(r[31:0]);
    endfunction

    function automatic t_eci_beat rotate_to_eci(t_orbit_beat b);
        longint si, ci, sn, cn, sp, cp;
        t_eci_beat o;
        si = turn_sine(b.incl);  ci = turn_cosine(b.incl);
        sn = turn_sine(b.node);  cn = turn_cosine(b.node);
        sp = turn_sine(b.peri);  cp = turn_cosine(b.peri);
        o.x = row_dot(q45_round(cn * cp * 32768 - sn * sp * ci),
                      q45_round(-cn * sp * 32768 - sn * cp * ci),
                      q45_round(sn * si * 32768), b.p, b.q, b.w);
        o.y = row_dot(q45_round(sn * cp * 32768 + cn * sp * ci),
                      q45_round(-sn * sp * 32768 + cn * cp * ci),
                      q45_round(-cn * si * 32768), b.p, b.q, b.w);
        o.z = row_dot(q45_round(sp * si * 32768), q45_round(cp * si * 32768),
                      q45_round(ci * 1073741824), b.p, b.q, b.w);
        return o;
    endfunction
endpackage

// ===== tb/sv/tb_top.sv =====
module tb_top;
    import p2i_pkg::*;
    import p2i_tb_pkg::*;

    localparam int NUM_RANDOM = 500;
    localparam int LATENCY    = PIPE_LAT;
    localparam int HOLD_LEN   = 60;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    p2i_in_if  in_ch();
    p2i_out_if out_ch();

    perifocal_to_inertial_rotation_top i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_orbit_beat pending_beats[$];
    int          pause_marks[$];   // index of item that waits for drain
    t_eci_beat   expected_eci[$];
    int          sent_cnt = 0;
    int          recv_cnt = 0;
    int          err_cnt  = 0;
    bit          stim_done = 1'b0;
    bit          hold_req = 1'b0;

    int send_gap = 0;
    int recv_gap = 0;
    int hold_cnt = 0;
    bit draining = 1'b0;

    function automatic t_vec rand_vec();
        case ($urandom_range(0, 5))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return t_vec'($urandom_range(0, 4096)) - 32'sd2048;
            default: return t_vec'($urandom);
        endcase
    endfunction

    function automatic t_angle rand_angle();
        case ($urandom_range(0, 4))
            0: return t_angle'($urandom_range(0, 3)) << (ANGLE_BITS - 2);
            1: return (t_angle'($urandom_range(0, 3)) << (ANGLE_BITS - 2))
                      + t_angle'($urandom_range(0, 4)) - t_angle'(2);
            default: return t_angle'($urandom);
        endcase
    endfunction

    function automatic t_orbit_beat make_beat(t_angle a0, t_angle a1, t_angle a2, t_vec p,
                                              t_vec q, t_vec w);
        t_orbit_beat b;
        b.incl = a0; b.node = a1; b.peri = a2; b.p = p; b.q = q; b.w = w;
        return b;
    endfunction

    initial begin
        t_vec vmax, vmin;
        vmax = 32'sh7fff_ffff;
        vmin = 32'sh8000_0000;
        // directed: zero angles, quarter-turn peaks, extremes, saturation
        pending_beats.push_back(make_beat(0, 0, 0, 1, 2, 3));
        pending_beats.push_back(make_beat(0, 0, 0, vmax, vmin, vmax));
        pending_beats.push_back(make_beat(16'h4000, 16'h4000, 16'h4000, vmax, vmax, vmax));
        pending_beats.push_back(make_beat(16'hc000, 16'hc000, 16'hc000, vmin, vmin, vmin));
        pending_beats.push_back(make_beat(16'h8000, 16'h8000, 16'h8000, vmax, 0, vmin));
        pending_beats.push_back(make_beat(16'hffff, 16'hffff, 16'hffff, vmin, vmax, vmin));
        pending_beats.push_back(make_beat(16'h2000, 16'h2000, 16'h2000, vmax, vmax, vmax));
        pending_beats.push_back(make_beat(16'h2000, 16'h6000, 16'ha000, vmin, vmin, vmin));
        pending_beats.push_back(make_beat(16'h1fff, 16'h3fff, 16'h4001, -1, -1, -1));
        pending_beats.push_back(make_beat(16'h5555, 16'haaaa, 16'h0001, 32'sh00ff_ffff,
                                          32'sh0100_0000, -32'sh0100_0000));
        pending_beats.push_back(make_beat(16'h0000, 16'h2000, 16'h6000, vmax, vmax, 0));
        pending_beats.push_back(make_beat(16'h7fff, 16'h8001, 16'hbfff, 0, 0, 0));
        for (int i = 0; i < NUM_RANDOM; i++)
            pending_beats.push_back(make_beat(rand_angle(), rand_angle(), rand_angle(),
                                              rand_vec(), rand_vec(), rand_vec()));
        pause_marks.push_back(200);
        pause_marks.push_back(400);
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_eci.push_back(rotate_to_eci(t_orbit_beat'{in_ch.inclination_angle,
                    in_ch.node_angle, in_ch.perigee_angle, in_ch.p_component,
                    in_ch.q_component, in_ch.w_component}));
                sent_cnt++;
            end
            if (in_ch.valid && !in_ch.ready) begin
                // hold current beat
            end else if (pause_marks.size() > 0 && sent_cnt == pause_marks[0]
                         && !(in_ch.valid && in_ch.ready)) begin
                in_ch.valid <= 1'b0;
                if (expected_eci.size() == 0) void'(pause_marks.pop_front());
            end else if (pause_marks.size() > 0 && in_ch.valid && in_ch.ready
                         && sent_cnt == pause_marks[0]) begin
                in_ch.valid <= 1'b0;
            end else if (send_gap > 0) begin
                in_ch.valid <= 1'b0;
                send_gap--;
            end else if (pending_beats.size() > 0) begin
                t_orbit_beat b;
                b = pending_beats.pop_front();
                in_ch.valid             <= 1'b1;
                in_ch.inclination_angle <= b.incl;
                in_ch.node_angle        <= b.node;
                in_ch.perigee_angle     <= b.peri;
                in_ch.p_component       <= b.p;
                in_ch.q_component       <= b.q;
                in_ch.w_component       <= b.w;
                send_gap = (sent_cnt % 150 < 40) ? 0 : $urandom_range(0, 10);
            end else begin
                in_ch.valid <= 1'b0;
                stim_done = 1'b1;
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_eci.size() == 0) begin
                    $display("%0t unexpected beat: actual %h %h %h", $time,
                             out_ch.x_inertial, out_ch.y_inertial, out_ch.z_inertial);
                    err_cnt++;
                end else begin
                    t_eci_beat e;
                    e = expected_eci.pop_front();
                    if (out_ch.x_inertial !== e.x) begin
                        $display("%0t x mismatch: expected %0d actual %0d", $time, e.x,
                                 out_ch.x_inertial);
                        err_cnt++;
                    end
                    if (out_ch.y_inertial !== e.y) begin
                        $display("%0t y mismatch: expected %0d actual %0d", $time, e.y,
                                 out_ch.y_inertial);
                        err_cnt++;
                    end
                    if (out_ch.z_inertial !== e.z) begin
                        $display("%0t z mismatch: expected %0d actual %0d", $time, e.z,
                                 out_ch.z_inertial);
                        err_cnt++;
                    end
                end
                recv_cnt++;
            end
            // long hold-off once, early in the random part
            if (recv_cnt == 60 && hold_cnt == 0 && !draining) begin
                draining = 1'b1;
                hold_cnt = HOLD_LEN;
            end
            if (hold_cnt > 0) begin
                out_ch.ready <= 1'b0;
                hold_cnt--;
            end else if (recv_gap > 0) begin
                out_ch.ready <= 1'b0;
                recv_gap--;
            end else begin
                out_ch.ready <= 1'b1;
                if (out_ch.valid && out_ch.ready)
                    recv_gap = ((recv_cnt % 130) < 35) ? 0 : $urandom_range(0, 10);
            end
        end
    end

    initial begin
        in_ch.valid             = 1'b0;
        in_ch.inclination_angle = '0;
        in_ch.node_angle        = '0;
        in_ch.perigee_angle     = '0;
        in_ch.p_component       = '0;
        in_ch.q_component       = '0;
        in_ch.w_component       = '0;
        out_ch.ready            = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done && expected_eci.size() == 0);
        repeat (LATENCY + 5) @(posedge i_clk);
        $display("Covered %0d vectors incl. quarter-turn peaks, extremes, saturation,",
                 sent_cnt);
        $display("input stalls under a long output hold-off, and drain pauses.");
        if (err_cnt == 0 && expected_eci.size() == 0)
            $display("PASS perifocal_to_inertial_rotation_top");
        else
            $display("FAIL perifocal_to_inertial_rotation_top");
        $finish;
    end

    initial begin
        #200000;
        $display("FAIL perifocal_to_inertial_rotation_top");
        $finish;
    end
endmodule

// ===== perifocal_to_inertial_rotation_top.f =====
+incdir+rtl
rtl/p2i_pkg.sv
rtl/p2i_if.sv
rtl/p2i_sine.sv
rtl/p2i_matrix.sv
rtl/p2i_lane.sv
rtl/perifocal_to_inertial_rotation_top.sv
rtl/p2i_check.sv
tb/sv/p2i_tb_pkg.sv
tb/sv/tb_top.sv
